/* sv/assert_macros.svh */
// assertion macros for the rtl files; only button_click_hold_detector includes them
// each macro samples on clk_i and is disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// overlapping implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/bchd_pkg.sv */
// shared types and constants for the button click / hold detector
// no dependencies
`timescale 1ns / 1ps

package bchd_pkg;

  localparam int unsigned MaskW        = 8;
  localparam int unsigned SlotLimit    = 8;
  localparam int unsigned TickW        = 15;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 15;
  localparam int unsigned NumButtonsDef = 8;

  localparam logic [TickW-1:0] HoldTicksRst  = TickW'(500);
  localparam logic [TickW-1:0] ClickTicksRst = TickW'(200);

  typedef enum logic [CfgIdxW-1:0] {
    RegEnable = 2'd0,
    RegHold   = 2'd1,
    RegClick  = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PhIdle       = 2'd0,
    PhWaitUp     = 2'd1,
    PhWaitPress2 = 2'd2,
    PhWaitUp2    = 2'd3
  } phase_e;

  typedef struct packed {
    logic click;
    logic dbl;
    logic hold;
  } lane_evt_t;

endpackage

/* sv/bchd_if.sv */
// channel interfaces: pin sweep request, result request, config write
// depends on bchd_pkg
`timescale 1ns / 1ps

interface bchd_sweep_if import bchd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MaskW-1:0] pin_levels;
  logic             tick_elapsed;

  modport source (output valid, pin_levels, tick_elapsed, input ready);
  modport sink   (input valid, pin_levels, tick_elapsed, output ready);
endinterface

interface bchd_result_if import bchd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MaskW-1:0] click_mask;
  logic [MaskW-1:0] double_click_mask;
  logic [MaskW-1:0] hold_mask;

  modport source (output valid, click_mask, double_click_mask, hold_mask, input ready);
  modport sink   (input valid, click_mask, double_click_mask, hold_mask, output ready);
endinterface

interface bchd_cfg_if import bchd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/bchd_lane.sv */
// one button lane: four-phase machine and 15-bit countdown
// depends on bchd_pkg
`timescale 1ns / 1ps

module bchd_lane import bchd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             step_i,
  input  logic             pressed_i,
  input  logic             tick_i,
  input  logic [TickW-1:0] hold_ticks_i,
  input  logic [TickW-1:0] click_ticks_i,
  output lane_evt_t        evt_o
);

  phase_e           phase_q, phase_d;
  logic [TickW-1:0] rem_q, rem_d;
  logic [TickW-1:0] rem_dec;
  logic             live;

  // countdown saturates at zero
  assign rem_dec = (tick_i && (rem_q != '0)) ? rem_q - TickW'(1) : rem_q;
  assign live    = (rem_dec != '0);

  always_comb begin
    phase_d = phase_q;
    if (!en_i) begin
      phase_d = PhIdle;
    end else if (step_i) begin
      case (phase_q)
        PhIdle: begin
          if (pressed_i) phase_d = PhWaitUp;
        end
        PhWaitUp: begin
          if (!pressed_i) begin
            if (live) phase_d = PhWaitPress2;
            else      phase_d = PhIdle;
          end
        end
        PhWaitPress2: begin
          if (pressed_i && live) phase_d = PhWaitUp2;
          else if (!live)        phase_d = PhIdle;
        end
        PhWaitUp2: begin
          if (!pressed_i) phase_d = PhIdle;
        end
        default: phase_d = PhIdle;
      endcase
    end
  end

  always_comb begin
    rem_d = rem_q;
    evt_o = '0;
    if (!en_i) begin
      rem_d = '0;
    end else if (step_i) begin
      rem_d = rem_dec;
      case (phase_q)
        PhIdle: begin
          if (pressed_i) rem_d = hold_ticks_i;
        end
        PhWaitUp: begin
          if (!pressed_i) begin
            if (live) begin
              rem_d = click_ticks_i;
            end else begin
              evt_o.hold = 1'b1;
              rem_d      = '0;
            end
          end
        end
        PhWaitPress2: begin
          if (pressed_i && live) begin
            rem_d = '0;
          end else if (!live) begin
            evt_o.click = 1'b1;
            rem_d       = '0;
          end
        end
        PhWaitUp2: begin
          if (!pressed_i) begin
            evt_o.dbl = 1'b1;
            rem_d     = '0;
          end
        end
        default: rem_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      rem_q   <= '0;
    end else begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
    end
  end

endmodule

/* sv/bchd_merge.sv */
// merge stage: packs lane events into result masks behind an output register
// depends on bchd_pkg
`timescale 1ns / 1ps

module bchd_merge import bchd_pkg::*; #(
  parameter int unsigned NUM_LANES = NumButtonsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lane_evt_t        evt_i [NUM_LANES],
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [MaskW-1:0] click_mask_o,
  output logic [MaskW-1:0] double_click_mask_o,
  output logic [MaskW-1:0] hold_mask_o
);

  logic             valid_q;
  logic             load;
  logic [MaskW-1:0] click_d, dbl_d, hold_d;
  logic [MaskW-1:0] click_q, dbl_q, hold_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    click_d = '0;
    dbl_d   = '0;
    hold_d  = '0;
    for (int unsigned i = 0; i < NUM_LANES; i++) begin
      click_d[i] = evt_i[i].click;
      dbl_d[i]   = evt_i[i].dbl;
      hold_d[i]  = evt_i[i].hold;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      click_q <= click_d;
      dbl_q   <= dbl_d;
      hold_q  <= hold_d;
    end
  end

  assign out_valid_o         = valid_q;
  assign click_mask_o        = click_q;
  assign double_click_mask_o = dbl_q;
  assign hold_mask_o         = hold_q;

endmodule

/* sv/button_click_hold_detector.sv */
// channel   | dir | payload
// sweep_i   | in  | pin_levels[7:0] (0 = pressed), tick_elapsed
// result_o  | out | click_mask, double_click_mask, hold_mask (8 bits each)
// cfg_i     | in  | index (0 enable_mask, 1 hold_ticks, 2 click_ticks), data
//
// one sweep accepted per cycle while sweep ready is high, results in the cycle after acceptance
// every button lane updates in the same cycle; results are held in the output register
// reset: all lanes idle with countdown 0, enable_mask 0, hold 500, click 200
// sweep ready drops only while a result is held and result_o is stalled
// config writes are always taken: cfg ready is tied high
`timescale 1ns / 1ps
`include "assert_macros.svh"

module button_click_hold_detector import bchd_pkg::*; #(
  parameter int unsigned NUM_BUTTONS = NumButtonsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bchd_sweep_if.sink    sweep_i,
  bchd_result_if.source result_o,
  bchd_cfg_if.sink      cfg_i
);

  localparam int unsigned NumLanes = (NUM_BUTTONS > SlotLimit) ? SlotLimit : NUM_BUTTONS;

  logic [MaskW-1:0] enable_q;
  logic [TickW-1:0] hold_ticks_q;
  logic [TickW-1:0] click_ticks_q;
  logic             step;
  lane_evt_t        evt [NumLanes];
  logic [MaskW-1:0] evt_twice;
  logic [MaskW-1:0] evt_off;

  // config registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q      <= '0;
      hold_ticks_q  <= HoldTicksRst;
      click_ticks_q <= ClickTicksRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegEnable: enable_q      <= cfg_i.data[MaskW-1:0];
        RegHold:   hold_ticks_q  <= cfg_i.data[TickW-1:0];
        RegClick:  click_ticks_q <= cfg_i.data[TickW-1:0];
        default: ;
      endcase
    end
  end

  assign step = sweep_i.valid && sweep_i.ready;

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    bchd_lane u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .en_i          (enable_q[i]),
      .step_i        (step),
      .pressed_i     (!sweep_i.pin_levels[i]),
      .tick_i        (sweep_i.tick_elapsed),
      .hold_ticks_i  (hold_ticks_q),
      .click_ticks_i (click_ticks_q),
      .evt_o         (evt[i])
    );
  end

  bchd_merge #(
    .NUM_LANES (NumLanes)
  ) u_merge (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (sweep_i.valid),
    .in_ready_o          (sweep_i.ready),
    .evt_i               (evt),
    .out_valid_o         (result_o.valid),
    .out_ready_i         (result_o.ready),
    .click_mask_o        (result_o.click_mask),
    .double_click_mask_o (result_o.double_click_mask),
    .hold_mask_o         (result_o.hold_mask)
  );

  // lanes with more than one event, and events on disabled slots
  assign evt_twice = (result_o.click_mask & result_o.double_click_mask)
                   | (result_o.click_mask & result_o.hold_mask)
                   | (result_o.double_click_mask & result_o.hold_mask);
  assign evt_off   = (result_o.click_mask | result_o.double_click_mask | result_o.hold_mask)
                   & ~enable_q;

  `ASSERT_NEXT(a_result_follows_request, step, result_o.valid, "accepted sweep left no result")
  `ASSERT_IMPLIES(a_one_event_per_lane, result_o.valid, ~|evt_twice, "lane reported two events")
  `ASSERT_IMPLIES(a_events_only_enabled, result_o.valid, ~|evt_off, "event for disabled slot")

endmodule
